// ===== hw/rtl/gb3_pkg.sv =====
// Shared constants and types of the 3x3 Gaussian blur stream.
package gb3_pkg;

  localparam int MAX_SIZE    = 2048;
  localparam int COL_W       = $clog2(MAX_SIZE);
  localparam int CFG_W       = 12;
  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds of one window: {bottom row, right column}
  localparam logic [1:0] KIND_MAIN      = 2'd0;
  localparam logic [1:0] KIND_RIGHT     = 2'd1;
  localparam logic [1:0] KIND_BOT       = 2'd2;
  localparam logic [1:0] KIND_BOT_RIGHT = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;

  // Window: [row top..bottom][col left..right]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // Border position of the results a window releases
  typedef struct packed {
    logic top;       // main result lies on image row 0
    logic left;      // main result lies on image column 0
    logic last_col;  // window also releases the last column
    logic last_row;  // window also releases the last row
  } cls_t;

  typedef struct packed {
    win_t win;
    cls_t cls;
  } entry_t;

endpackage

// ===== hw/rtl/gb3_stream_if.sv =====
// Stream and configuration interfaces of the blur block.
interface gb3_pix_if;
  import gb3_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_in;
  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

interface gb3_res_if;
  import gb3_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_out;
  logic run_last;
  logic frame_end;
  modport source(output valid, output pixel_out, output run_last, output frame_end,
                 input ready);
  modport sink(input valid, input pixel_out, input run_last, input frame_end,
               output ready);
endinterface

interface gb3_cfg_if;
  import gb3_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_W-1:0] image_size;
  modport source(output valid, output image_size, input ready);
  modport sink(input valid, input image_size, output ready);
endinterface

// ===== hw/rtl/gb3_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gb3_front.sv =====
// Front part: accepts pixels, keeps line stores and window, classifies results.
module gb3_front (
  input  logic            clk,
  input  logic            rst_n,
  gb3_pix_if.sink         in_ch,
  gb3_cfg_if.sink         cfg_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output gb3_pkg::entry_t push_data
);
  import gb3_pkg::*;

  logic [CFG_W-1:0] size_r;
  logic [CFG_W-1:0] side;
  logic [COL_W-1:0] last;
  logic [COL_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             acc;
  logic             cfg_wr;

  // Stage 1 registers (RAM read in flight)
  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_c0_r;
  logic             s1_rle1_r;
  cls_t             s1_cls_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_px_r;
  logic             s1_go;

  pix_t             above;
  pix_t             above_b;
  pix_t             above2;
  win_t             win_r, win_nxt;
  pix_t             v [3];

  // Clamp the configured side to the supported range
  always_comb begin
    if (size_r < CFG_W'(2)) begin
      side = CFG_W'(2);
    end else if (size_r > CFG_W'(MAX_SIZE)) begin
      side = CFG_W'(MAX_SIZE);
    end else begin
      side = size_r;
    end
  end
  assign last = COL_W'(side - CFG_W'(1));

  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Stage 1 drains when its beat needs no queue slot or one is free
  assign s1_go       = s1_valid_r & (~s1_emit_r | push_ready);
  assign in_ch.ready = ~s1_valid_r | s1_go;
  assign acc         = in_ch.valid & in_ch.ready;

  // Hold the image size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_W'(MAX_SIZE);
    end else if (cfg_wr) begin
      size_r <= cfg_ch.image_size;
    end
  end

  // Advance the raster position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (col_r == last) begin
      col_nxt = '0;
      row_nxt = (row_r == last) ? '0 : row_r + COL_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Classify the beat while the line stores are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r         <= (row_r != '0) && (col_r != '0);
      s1_c0_r           <= (col_r == '0);
      s1_rle1_r         <= (row_r <= COL_W'(1));
      s1_cls_r.top      <= (row_r == COL_W'(1));
      s1_cls_r.left     <= (col_r == COL_W'(1));
      s1_cls_r.last_col <= (col_r == last);
      s1_cls_r.last_row <= (row_r == last);
      s1_col_r          <= col_r;
      s1_px_r           <= in_ch.pixel_in;
    end
  end

  // Line store a: row above; line store b: two rows above
  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_line_a (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (acc),
    .raddr (col_r),
    .rdata (above)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_line_b (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (above),
    .re    (acc),
    .raddr (col_r),
    .rdata (above_b)
  );

  assign above2 = s1_rle1_r ? above : above_b;

  // Shift the window, or refill it at column zero
  always_comb begin
    v[0] = above2;
    v[1] = above;
    v[2] = s1_px_r;
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      if (s1_c0_r) begin
        win_nxt[i][0] = v[i];
        win_nxt[i][1] = v[i];
      end else begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[i][2] = v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  assign push_valid    = s1_valid_r & s1_emit_r;
  assign push_data.win = win_nxt;
  assign push_data.cls = s1_cls_r;

endmodule

// ===== hw/rtl/gb3_queue.sv =====
// Short register queue between front and back parts.
module gb3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gb3_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop,
  output gb3_pkg::entry_t pop_data
);
  import gb3_pkg::*;

  entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;
  assign pop_data   = slot_r[rptr_r];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gb3_back.sv =====
// Back part: walks the results of each window; filters one per cycle while the output is taken.
module gb3_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  gb3_pkg::entry_t q_data,
  gb3_res_if.source       out_ch
);
  import gb3_pkg::*;

  // Reciprocal of nine, scaled by 2^15, exact for corner sums below 2296
  localparam int RECIP_SH = 15;
  localparam logic [11:0] RECIP9 = 12'd3641;

  logic [1:0]  kind_r, kind_nxt;
  logic        is_last;
  logic        load;
  logic        rs, cs;
  logic        top, bot, left, right;
  logic        corner;
  pix_t        k [3][3];
  logic [1:0]  ri [3];
  logic [1:0]  cj [3];
  logic [1:0]  vr, hc;
  logic [11:0] gsum;
  logic [11:0] csum;
  logic [23:0] cprod;
  pix_t        res;

  logic        out_valid_r;
  pix_t        pixel_r;
  logic        run_last_r;
  logic        frame_end_r;

  // Pick the next kind of result for this window
  always_comb begin
    kind_nxt = KIND_MAIN;
    is_last  = 1'b1;
    case (kind_r)
      KIND_MAIN: begin
        if (q_data.cls.last_col) begin
          kind_nxt = KIND_RIGHT;
          is_last  = 1'b0;
        end else if (q_data.cls.last_row) begin
          kind_nxt = KIND_BOT;
          is_last  = 1'b0;
        end
      end
      KIND_RIGHT: begin
        if (q_data.cls.last_row) begin
          kind_nxt = KIND_BOT;
          is_last  = 1'b0;
        end
      end
      KIND_BOT: begin
        if (q_data.cls.last_col) begin
          kind_nxt = KIND_BOT_RIGHT;
          is_last  = 1'b0;
        end
      end
      default: begin
        kind_nxt = KIND_MAIN;
        is_last  = 1'b1;
      end
    endcase
  end

  // Select the kernel taps, replicating the edge row or column
  always_comb begin
    rs    = kind_r[1];
    cs    = kind_r[0];
    top   = q_data.cls.top & ~rs;
    bot   = rs;
    left  = q_data.cls.left & ~cs;
    right = cs;
    for (int i = 0; i < 3; i++) begin
      ri[i] = rs ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
      cj[i] = cs ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k[i][j] = q_data.win[ri[i]][cj[j]];
      end
    end
  end

  // Gaussian sum and corner sum
  always_comb begin
    corner = (top | bot) & (left | right);
    vr     = top ? 2'd2 : 2'd0;
    hc     = left ? 2'd2 : 2'd0;
    gsum   = 12'(k[0][0]) + {3'd0, k[0][1], 1'b0} + 12'(k[0][2])
           + {3'd0, k[1][0], 1'b0} + {2'd0, k[1][1], 2'b0} + {3'd0, k[1][2], 1'b0}
           + 12'(k[2][0]) + {3'd0, k[2][1], 1'b0} + 12'(k[2][2]);
    csum   = {2'd0, k[1][1], 2'b0} + {3'd0, k[1][hc], 1'b0}
           + {3'd0, k[vr][1], 1'b0} + 12'(k[vr][hc]);
    cprod  = csum * RECIP9;
    res    = corner ? cprod[RECIP_SH +: PIX_W] : gsum[11:4];
  end

  // Load the output register when it is empty or being taken
  assign load  = q_valid & (~out_valid_r | out_ch.ready);
  assign q_pop = load & is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_MAIN;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        kind_r      <= is_last ? KIND_MAIN : kind_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r     <= res;
      run_last_r  <= is_last;
      frame_end_r <= (kind_r == KIND_BOT_RIGHT);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = pixel_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

// ===== hw/rtl/gaussian_blur_3x3_stream.sv =====
// Path of a result: stage 1 registers, a queue slot, then the output register.
// Throughput: one pixel beat per cycle while the queue has room; the back part delivers
// one result beat per cycle while it is taken. A 4-deep queue absorbs the extra result at
// each row end; on the last row emitting beats give two or more results, so input slows.
// Reset: position zero, size 2048, window zero, queue and output empty; line stores kept.
// Top level of the 3x3 Gaussian blur stream: front, queue and back parts.
module gaussian_blur_3x3_stream (
  input  logic      clk,
  input  logic      rst_n,
  gb3_pix_if.sink   in_ch,
  gb3_res_if.source out_ch,
  gb3_cfg_if.sink   cfg_ch
);
  import gb3_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   q_valid;
  logic   q_pop;
  entry_t q_data;

  // Accept, store lines and classify
  gb3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple the two parts
  gb3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Filter and deliver result beats
  gb3_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
